### src/wsct_pkg.sv
// wsct_pkg: shared widths, register indexes and limits for the window-sum
// closest-target search block. No dependencies; used by the result
// interface, the top level and the testbench.
package wsct_pkg;

  // Result field widths
  localparam int unsigned POS_W  = 10;
  localparam int unsigned DIFF_W = 21;
  localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned DIM_W      = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 2'd2;

  // Smallest legal grid dimension
  localparam int unsigned MIN_DIM = 3;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [DIFF_W-1:0] diff_t;

endpackage

### src/wsct_sample_if.sv
// wsct_sample_if: valid/ready channel carrying one grid sample per beat.
// Depends on nothing but its SAMPLE_BITS parameter.
interface wsct_sample_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### src/wsct_result_if.sv
// wsct_result_if: valid/ready channel carrying the best cell of a frame.
// Depends on wsct_pkg for the field types.
interface wsct_result_if;
  import wsct_pkg::*;

  logic  valid;
  logic  ready;
  pos_t  best_row;
  pos_t  best_col;
  diff_t best_diff;

  modport source (output valid, output best_row, output best_col, output best_diff,
                  input ready);
  modport sink   (input valid, input best_row, input best_col, input best_diff,
                  output ready);
endinterface

### src/window_sum_closest_target_search.sv
// window_sum_closest_target_search: 3x3 box sum over a raster grid, tracks
// the interior cell whose sum is closest to a target. Depends on wsct_pkg,
// wsct_sample_if and wsct_result_if.
//
//   channel   dir  beat contents                       handshake
//   -------   ---  ----------------------------------  ---------------
//   samples   in   sample (signed, SAMPLE_BITS)        valid/ready
//   results   out  best_row, best_col, best_diff       valid/ready
//   cfg       in   cfg_index, cfg_data                 cfg_we, no wait
//
// One sample per cycle while samples.ready is high. A sample passes through
// the window registers (loaded with the line buffer on the accept edge), then
// the registered sum/distance stage, then the compare that updates the
// best-cell registers. The frame result is loaded into the output register
// when the compare stage consumes its registered distance. The line buffers
// are one memory with a registered read, prefetched at the next column. Reset
// is synchronous and clears counters, best-cell state and the output valid
// flag. samples.ready drops only while a frame result waits in the output
// register and the next frame end reaches the compare stage.
module window_sum_closest_target_search #(
  parameter int unsigned MAX_COLS    = 1024,
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wsct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsct_pkg::CFG_DATA_W-1:0]     cfg_data,
  wsct_sample_if.sink                         samples,
  wsct_result_if.source                       results
);
  import wsct_pkg::*;

  localparam int unsigned CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CCW0 = $clog2(MAX_COLS + 1);
  localparam int unsigned RCW0 = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW  = (CCW0 > DIM_W) ? CCW0 : DIM_W;
  localparam int unsigned RCW  = (RCW0 > DIM_W) ? RCW0 : DIM_W;
  localparam int unsigned SUMW = SAMPLE_BITS + 4;
  localparam int unsigned DW   = ((SUMW > DIFF_W) ? SUMW : DIFF_W) + 2;
  localparam int unsigned MW   = 2 * SAMPLE_BITS;

  // Configuration registers
  logic signed [DIFF_W-1:0] target_sum;
  logic [DIM_W-1:0]         grid_rows;
  logic [DIM_W-1:0]         grid_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
      grid_rows  <= DIM_W'(MIN_DIM);
      grid_cols  <= DIM_W'(MIN_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_SUM: target_sum <= $signed(cfg_data[DIFF_W-1:0]);
        CFG_GRID_ROWS:  grid_rows  <= cfg_data[DIM_W-1:0];
        CFG_GRID_COLS:  grid_cols  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped grid size
  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;

  always_comb begin
    if (grid_rows < DIM_W'(MIN_DIM))
      rows_eff = RCW'(MIN_DIM);
    else if (RCW'(grid_rows) > RCW'(MAX_ROWS))
      rows_eff = RCW'(MAX_ROWS);
    else
      rows_eff = RCW'(grid_rows);
    if (grid_cols < DIM_W'(MIN_DIM))
      cols_eff = CCW'(MIN_DIM);
    else if (CCW'(grid_cols) > CCW'(MAX_COLS))
      cols_eff = CCW'(MAX_COLS);
    else
      cols_eff = CCW'(grid_cols);
  end

  // Pipeline control
  logic stall;
  logic accept;
  logic v1, v2;

  logic out_valid;
  logic last2;
  assign stall         = v2 && last2 && out_valid && !results.ready;
  assign samples.ready = !stall;
  assign accept        = samples.valid && samples.ready;

  // Raster position
  logic [CW-1:0]  col_count, col_count_next;
  logic [RW-1:0]  row_count, row_count_next;
  logic           row_end, frame_end;
  logic [CCW-1:0] col_inc;
  logic [RCW-1:0] row_inc;

  always_comb begin
    col_inc   = CCW'(col_count) + CCW'(1);
    row_inc   = RCW'(row_count) + RCW'(1);
    row_end   = (col_inc >= cols_eff);
    frame_end = row_end && (row_inc >= rows_eff);
    col_count_next = row_end ? '0 : col_inc[CW-1:0];
    if (!row_end)
      row_count_next = row_count;
    else if (frame_end)
      row_count_next = '0;
    else
      row_count_next = row_inc[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // Line buffers: {upper, middle} per column, read prefetched at next column
  logic [MW-1:0] line_mem [MAX_COLS];
  logic [MW-1:0] line_rd;
  logic [CW-1:0] rd_addr;
  logic signed [SAMPLE_BITS-1:0] up_px, mid_px;

  assign rd_addr = rst ? '0 : (accept ? col_count_next : col_count);
  assign up_px   = $signed(line_rd[MW-1:SAMPLE_BITS]);
  assign mid_px  = $signed(line_rd[SAMPLE_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (accept)
      line_mem[col_count] <= {mid_px, samples.sample};
    line_rd <= line_mem[rd_addr];
  end

  // Stage 1: 3x3 window, [column age][upper, middle, current]
  logic signed [SAMPLE_BITS-1:0] window_regs [3][3];
  logic calc1, last1;
  pos_t row1, col1;
  logic [RW-1:0] row_dec;
  logic [CW-1:0] col_dec;

  assign row_dec = row_count - RW'(1);
  assign col_dec = col_count - CW'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 3; j++)
          window_regs[i][j] <= window_regs[i+1][j];
      window_regs[2][0] <= up_px;
      window_regs[2][1] <= mid_px;
      window_regs[2][2] <= samples.sample;
      calc1 <= (RCW'(row_count) >= RCW'(2)) && (CCW'(col_count) >= CCW'(2));
      last1 <= frame_end;
      row1  <= POS_W'(row_dec);
      col1  <= POS_W'(col_dec);
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      v1 <= 1'b0;
    else if (!stall)
      v1 <= accept;
  end

  // Stage 2: window sum and saturated distance to target
  logic signed [SUMW-1:0] win_sum;
  logic signed [DW-1:0]   diff;
  logic [DW-1:0]          mag;
  diff_t                  sat_dist;

  always_comb begin
    win_sum = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win_sum = win_sum + SUMW'(window_regs[i][j]);
    diff     = DW'(target_sum) - DW'(win_sum);
    mag      = diff[DW-1] ? DW'(-diff) : DW'(diff);
    sat_dist = (mag > DW'(DIFF_MAX)) ? DIFF_MAX : mag[DIFF_W-1:0];
  end

  logic  calc2;
  pos_t  row2, col2;
  diff_t dist2;

  always_ff @(posedge clk) begin
    if (!stall && v1) begin
      calc2 <= calc1;
      last2 <= last1;
      row2  <= row1;
      col2  <= col1;
      dist2 <= sat_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      v2 <= 1'b0;
    else if (!stall)
      v2 <= v1;
  end

  // Stage 3: running best, first cell wins a tie
  logic  have_best;
  diff_t best_distance;
  pos_t  best_row_reg, best_col_reg;
  logic  take;
  logic  consume;
  diff_t upd_dist;
  pos_t  upd_row, upd_col;

  assign consume = v2 && !stall;
  assign take    = calc2 && (!have_best || (dist2 < best_distance));

  always_comb begin
    upd_dist = take ? dist2 : best_distance;
    upd_row  = take ? row2  : best_row_reg;
    upd_col  = take ? col2  : best_col_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best     <= 1'b0;
      best_distance <= '0;
      best_row_reg  <= '0;
      best_col_reg  <= '0;
    end else if (consume) begin
      if (last2) begin
        have_best     <= 1'b0;
        best_distance <= '0;
        best_row_reg  <= '0;
        best_col_reg  <= '0;
      end else if (take) begin
        have_best     <= 1'b1;
        best_distance <= dist2;
        best_row_reg  <= row2;
        best_col_reg  <= col2;
      end
    end
  end

  // Output register
  pos_t  out_row, out_col;
  diff_t out_diff;

  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (consume && last2)
      out_valid <= 1'b1;
    else if (results.ready)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (consume && last2) begin
      out_row  <= upd_row;
      out_col  <= upd_col;
      out_diff <= upd_dist;
    end
  end

  assign results.valid     = out_valid;
  assign results.best_row  = out_row;
  assign results.best_col  = out_col;
  assign results.best_diff = out_diff;

  // Checks
  a_ready_only_drops_on_full_output: assert property (
    @(posedge clk) disable iff (rst) !samples.ready |-> results.valid
  ) else $error("input stalled with no pending result");

  a_col_in_range: assert property (
    @(posedge clk) disable iff (rst) (CCW'(col_count) < CCW'(MAX_COLS))
  ) else $error("column counter past line buffer depth");

  a_best_cleared_after_frame: assert property (
    @(posedge clk) disable iff (rst) (consume && last2) |=> (!have_best && out_valid)
  ) else $error("best state not cleared or result missing after frame end");

  a_candidate_sets_best: assert property (
    @(posedge clk) disable iff (rst) (consume && calc2 && !last2) |=> have_best
  ) else $error("interior cell left no candidate");

endmodule

### dv/wsct_best_checker.sv
`timescale 1ns / 100ps
// wsct_best_checker: watches the sample, result and config ports of the
// window-sum closest-target block, predicts each frame's best cell and compares.
// Depends on wsct_pkg, wsct_sample_if and wsct_result_if.
module wsct_best_checker #(
  parameter int unsigned MAX_COLS    = 1024,
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wsct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wsct_pkg::CFG_DATA_W-1:0] cfg_data,
  wsct_sample_if                          samples,
  wsct_result_if                          results,
  output int                              err_cnt,
  output int                              pending,
  output int                              cells_checked
);
  import wsct_pkg::*;

  typedef struct packed {
    pos_t  row;
    pos_t  col;
    diff_t diff;
  } best_cell_t;

  // Expected best cell of every finished frame, oldest first
  best_cell_t best_cell_q[$];

  // Shadow configuration
  logic signed [DIFF_W-1:0] target;
  logic [DIM_W-1:0]         rows_cfg;
  logic [DIM_W-1:0]         cols_cfg;

  // Two rows back, one row back, and the 3x3 window [column age][row]
  logic signed [SAMPLE_BITS-1:0] row_two_back [MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] row_one_back [MAX_COLS];
  logic signed [SAMPLE_BITS-1:0] win [3][3];

  int unsigned row_pos;
  int unsigned col_pos;
  longint      best_dist;
  int unsigned best_r;
  int unsigned best_c;
  bit          have_best;

  // Out-of-range sizes are pulled into 3..hi
  function automatic int unsigned dim_used(logic [DIM_W-1:0] v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  always @(posedge clk) begin : track
    int unsigned                   rows;
    int unsigned                   cols;
    logic signed [SAMPLE_BITS-1:0] up;
    logic signed [SAMPLE_BITS-1:0] mid;
    logic signed [SAMPLE_BITS-1:0] cur;
    longint                        sum;
    longint                        win_dist;
    best_cell_t                    exp_cell;
    if (rst) begin
      target        = '0;
      rows_cfg      = DIM_W'(MIN_DIM);
      cols_cfg      = DIM_W'(MIN_DIM);
      row_pos       = 0;
      col_pos       = 0;
      best_dist     = 0;
      best_r        = 0;
      best_c        = 0;
      have_best     = 1'b0;
      err_cnt       = 0;
      pending       = 0;
      cells_checked = 0;
      best_cell_q.delete();
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = '0;
    end else begin
      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_SUM: target = cfg_data;
          CFG_GRID_ROWS:  rows_cfg = cfg_data[DIM_W-1:0];
          CFG_GRID_COLS:  cols_cfg = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end

      // Result beat against the oldest expectation
      if (results.valid && results.ready) begin
        if (best_cell_q.size() == 0) begin
          $error("best-cell beat with nothing expected: row %0d col %0d diff %0d",
                 results.best_row, results.best_col, results.best_diff);
          err_cnt++;
        end else begin
          exp_cell = best_cell_q.pop_front();
          cells_checked++;
          if (results.best_row !== exp_cell.row) begin
            $error("best_row: expected %0d, got %0d", exp_cell.row, results.best_row);
            err_cnt++;
          end
          if (results.best_col !== exp_cell.col) begin
            $error("best_col: expected %0d, got %0d", exp_cell.col, results.best_col);
            err_cnt++;
          end
          if (results.best_diff !== exp_cell.diff) begin
            $error("best_diff: expected %0d, got %0d", exp_cell.diff, results.best_diff);
            err_cnt++;
          end
        end
      end

      // Sample beat: line buffers, window, running best
      if (samples.valid && samples.ready) begin
        rows = dim_used(rows_cfg, MAX_ROWS);
        cols = dim_used(cols_cfg, MAX_COLS);
        cur  = samples.sample;
        up   = row_two_back[col_pos];
        mid  = row_one_back[col_pos];
        row_two_back[col_pos] = mid;
        row_one_back[col_pos] = cur;
        for (int j = 0; j < 3; j++) begin
          win[0][j] = win[1][j];
          win[1][j] = win[2][j];
        end
        win[2][0] = up;
        win[2][1] = mid;
        win[2][2] = cur;

        // Interior cell: window centered one row and one column back
        if (row_pos >= 2 && col_pos >= 2) begin
          sum = 0;
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) sum += win[i][j];
          win_dist = longint'(target) - sum;
          if (win_dist < 0) win_dist = -win_dist;
          if (win_dist > longint'(DIFF_MAX)) win_dist = longint'(DIFF_MAX);
          // strict less-than: ties keep the earlier cell
          if (!have_best || win_dist < best_dist) begin
            have_best = 1'b1;
            best_dist = win_dist;
            best_r    = row_pos - 1;
            best_c    = col_pos - 1;
          end
        end

        // Row and frame end
        if (col_pos + 1 >= cols) begin
          col_pos = 0;
          if (row_pos + 1 >= rows) begin
            exp_cell.row  = best_r[POS_W-1:0];
            exp_cell.col  = best_c[POS_W-1:0];
            exp_cell.diff = best_dist[DIFF_W-1:0];
            best_cell_q.push_back(exp_cell);
            row_pos   = 0;
            have_best = 1'b0;
            best_dist = 0;
            best_r    = 0;
            best_c    = 0;
            for (int i = 0; i < 3; i++)
              for (int j = 0; j < 3; j++) win[i][j] = '0;
          end else begin
            row_pos = row_pos + 1;
          end
        end else begin
          col_pos = col_pos + 1;
        end
      end
      pending = best_cell_q.size();
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: drives grid frames and register settings into the window-sum
// closest-target block, with random gaps on both channels; the verdict comes
// from wsct_best_checker. Depends on wsct_pkg and both channel interfaces.
module tb_top;
  import wsct_pkg::*;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_COLS    = 1024;
  localparam int unsigned MAX_ROWS    = 1024;
  localparam int RAND_ITEMS = 1380;
  localparam int MIN_FRAMES = 30;
  localparam int DRAIN      = 12;
  localparam int LIMIT      = 400000;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam int TARGET_LO = -1048576;
  localparam int TARGET_HI = 1048575;

  typedef enum {PAT_RANDOM, PAT_LOW, PAT_HIGH, PAT_ALT, PAT_EDGE_COLS, PAT_EDGE_ROWS} pattern_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int err_cnt;
  int pending;
  int cells_checked;
  int idle_pct = 0;
  int frame_rows = MIN_DIM;
  int frame_cols = MIN_DIM;
  int samples_sent = 0;
  int frames_sent = 0;
  int cycle_cnt = 0;

  wsct_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp ();
  wsct_result_if res ();

  window_sum_closest_target_search #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .samples  (smp),
    .results  (res)
  );

  wsct_best_checker #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .samples      (smp),
    .results      (res),
    .err_cnt      (err_cnt),
    .pending      (pending),
    .cells_checked(cells_checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result receiver: ready drops at random, in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        res.ready  <= 1'b0;
        stall_left = $urandom_range(0, 14);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  function automatic int dim_used(int raw, int hi);
    int v;
    v = raw & 'h7FF;
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(pattern_t pat, int r, int c);
    int v;
    case (pat)
      PAT_LOW:       return SAMPLE_LO;
      PAT_HIGH:      return SAMPLE_HI;
      PAT_ALT:       return ((r + c) % 2 != 0) ? SAMPLE_HI : SAMPLE_LO;
      PAT_EDGE_COLS: return (c >= frame_cols - 3) ? '0 : SAMPLE_BITS'(100);
      PAT_EDGE_ROWS: return (r >= frame_rows - 3) ? '0 : SAMPLE_BITS'(100);
      default: begin
        case ($urandom_range(0, 7))
          0, 1:    v = $urandom();
          2:       v = $urandom_range(0, 1) ? int'(SAMPLE_HI) : int'(SAMPLE_LO);
          3, 4:    v = int'($urandom_range(0, 8)) - 4;   // narrow range, many ties
          default: v = int'($urandom_range(0, 4000)) - 2000;
        endcase
        return v[SAMPLE_BITS-1:0];
      end
    endcase
  endfunction

  // Drop valid and wait until every frame result has come back
  task automatic wait_idle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Writes all three registers, only while the block is idle
  task automatic set_config(input int target, input int rows_raw, input int cols_raw);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TARGET_SUM;
    cfg_data  <= target[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_GRID_ROWS;
    cfg_data  <= CFG_DATA_W'(rows_raw & 'h7FF);
    @(posedge clk);
    cfg_index <= CFG_GRID_COLS;
    cfg_data  <= CFG_DATA_W'(cols_raw & 'h7FF);
    @(posedge clk);
    cfg_we     <= 1'b0;
    frame_rows = dim_used(rows_raw, MAX_ROWS);
    frame_cols = dim_used(cols_raw, MAX_COLS);
  endtask

  // One sample beat, with an optional gap before it
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] v);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 15);
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid  <= 1'b1;
    smp.sample <= v;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic run_frame(input pattern_t pat);
    for (int r = 0; r < frame_rows; r++)
      for (int c = 0; c < frame_cols; c++) push_sample(pick_sample(pat, r, c));
    frames_sent++;
  endtask

  // Stimulus
  initial begin
    int rand_items;
    int rand_frames;
    int n_frames;
    int t;
    int dims [2];
    rand_items  = 0;
    rand_frames = 0;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_TARGET_SUM;
    cfg_data   <= '0;
    smp.valid  <= 1'b0;
    smp.sample <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, then sample and target extremes
    idle_pct = 10;
    run_frame(PAT_ALT);
    set_config(TARGET_HI, 0, 1);          // sizes below range clamp to 3
    run_frame(PAT_LOW);                   // largest possible difference
    set_config(TARGET_LO, 2, 3);
    run_frame(PAT_HIGH);
    // Wide and tall grids with the best cell at the far edge
    set_config(0, 3, 40);
    run_frame(PAT_EDGE_COLS);             // best at column 38
    set_config(0, 40, 3);
    run_frame(PAT_EDGE_ROWS);             // best at row 38

    // Random settings and frames; the last fifth runs without gaps
    while (rand_items < RAND_ITEMS || rand_frames < MIN_FRAMES) begin
      case ($urandom_range(0, 3))
        0:       t = int'($urandom_range(0, 2097151)) + TARGET_LO;
        1:       t = int'($urandom_range(0, 40000)) - 20000;
        2:       t = int'($urandom_range(0, 20)) - 10;
        default: t = $urandom_range(0, 1) ? TARGET_HI : TARGET_LO;
      endcase
      for (int k = 0; k < 2; k++) begin
        if ($urandom_range(0, 9) == 0)       dims[k] = $urandom_range(0, 2);
        else if ($urandom_range(0, 14) == 0) dims[k] = $urandom_range(9, 40);
        else                                 dims[k] = $urandom_range(3, 8);
      end
      set_config(t, dims[0], dims[1]);
      if (rand_items >= RAND_ITEMS * 4 / 5) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       idle_pct = 0;
          1:       idle_pct = 5;
          2:       idle_pct = 20;
          default: idle_pct = 40;
        endcase
      end
      n_frames = $urandom_range(1, 3);
      for (int f = 0; f < n_frames; f++) begin
        run_frame(PAT_RANDOM);
        rand_items += frame_rows * frame_cols;
        rand_frames++;
      end
    end

    wait_idle();
    $display("Sent %0d samples in %0d frames, grids from 3x3 up to 40 rows or columns,",
             samples_sent, frames_sent);
    $display("undersized settings, extreme samples and targets; %0d results, %0d mismatches.",
             cells_checked, err_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
